// ===== hdl/ialu_pkg.sv =====
// shared types, constants and operation codes of the 64-bit integer alu
package ialu_pkg;

    // datapath width, low bits of each operand are used
    localparam int DATA_WIDTH = 64;
    localparam int FIELD_WIDTH = 64;
    localparam int MODE_WIDTH = 4;
    localparam int SHAMT_WIDTH = 6;

    // operation codes
    localparam logic [MODE_WIDTH-1:0] MODE_ADD = 4'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_SUB = 4'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_MUL = 4'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_DIV = 4'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_REM = 4'd4;
    localparam logic [MODE_WIDTH-1:0] MODE_AND = 4'd5;
    localparam logic [MODE_WIDTH-1:0] MODE_OR  = 4'd6;
    localparam logic [MODE_WIDTH-1:0] MODE_XOR = 4'd7;
    localparam logic [MODE_WIDTH-1:0] MODE_SHL = 4'd8;
    localparam logic [MODE_WIDTH-1:0] MODE_SHR = 4'd9;

    // one request in flight along the cell row
    typedef struct packed {
        logic                  valid;
        logic [MODE_WIDTH-1:0] mode;
        logic                  err;
        logic                  neg_res;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] dq;
        logic [DATA_WIDTH-1:0] dvs;
        logic [DATA_WIDTH-1:0] acc;
        logic [DATA_WIDTH-1:0] ma;
        logic [DATA_WIDTH-1:0] mb;
        logic [DATA_WIDTH-1:0] simple;
    } t_item;

endpackage

// ===== hdl/ialu_req_if.sv =====
// request channel of the alu: operation and operands
interface ialu_req_if;
    logic                                valid;
    logic                                ready;
    logic [ialu_pkg::MODE_WIDTH-1:0]     mode;
    logic                                op_signed;
    logic [ialu_pkg::FIELD_WIDTH-1:0]    operand_a;
    logic [ialu_pkg::FIELD_WIDTH-1:0]    operand_b;

    modport source (output valid, mode, op_signed, operand_a, operand_b, input ready);
    modport sink (input valid, mode, op_signed, operand_a, operand_b, output ready);
endinterface

// ===== hdl/ialu_rsp_if.sv =====
// response channel of the alu: result and divide error
interface ialu_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [ialu_pkg::FIELD_WIDTH-1:0]    result_value;
    logic                                divide_error;

    modport source (output valid, result_value, divide_error, input ready);
    modport sink (input valid, result_value, divide_error, output ready);
endinterface

// ===== hdl/ialu_cell.sv =====
// one cell of the row: one restoring divide step and one shift-add multiply step
module ialu_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  ialu_pkg::t_item i_item,
    output ialu_pkg::t_item o_item
);
    localparam int W = ialu_pkg::DATA_WIDTH;

    ialu_pkg::t_item r_item;
    ialu_pkg::t_item n_item;
    logic [W:0]      shifted;
    logic [W:0]      diff;

    // divide step and multiply step
    always_comb begin
        n_item  = i_item;
        shifted = {i_item.rem, i_item.dq[W-1]};
        diff    = shifted - {1'b0, i_item.dvs};
        if (!diff[W]) begin
            n_item.rem = diff[W-1:0];
        end else begin
            n_item.rem = shifted[W-1:0];
        end
        n_item.dq  = {i_item.dq[W-2:0], ~diff[W]};
        n_item.acc = i_item.acc + (i_item.mb[0] ? i_item.ma : '0);
        n_item.ma  = {i_item.ma[W-2:0], 1'b0};
        n_item.mb  = {1'b0, i_item.mb[W-1:1]};
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;
endmodule

// ===== hdl/integer_alu_64bit.sv =====
// top level of the pipelined 64-bit integer alu built from a row of step cells
//
//  channel  dir  modport  payload
//  i_req    in   sink     mode, op_signed, operand_a, operand_b
//  o_rsp    out  source   result_value, divide_error
//
// one request per cycle while the response is not stalled; DATA_WIDTH + 2
// register stages (entry register, one cell per quotient bit and multiplier
// bit, result register) lie between an accepted request and its response.
// the row holds DATA_WIDTH cells; throughput is one per cycle while the row moves.
// synchronous active-low reset clears every stage valid bit.
// a stalled response holds the whole row; bubbles are not squeezed out.
module integer_alu_64bit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ialu_req_if.sink   i_req,
    ialu_rsp_if.source o_rsp
);
    localparam int W = ialu_pkg::DATA_WIDTH;

    ialu_pkg::t_item               n_entry;
    ialu_pkg::t_item               r_entry;
    ialu_pkg::t_item               row [W+1];
    logic                          en;
    logic [W-1:0]                  a;
    logic [W-1:0]                  b;
    logic                          na;
    logic                          nb;
    logic [ialu_pkg::SHAMT_WIDTH-1:0] sh;
    logic                          sh_big;
    logic [W-1:0]                  n_res;
    logic                          r_out_valid;
    logic [W-1:0]                  r_out_res;
    logic                          r_out_err;

    // whole row advances unless the response is held
    assign en          = !r_out_valid || o_rsp.ready;
    assign i_req.ready = en;

    // entry decode: magnitudes for divide and the simple operations
    always_comb begin
        a      = i_req.operand_a[W-1:0];
        b      = i_req.operand_b[W-1:0];
        sh     = i_req.operand_b[ialu_pkg::SHAMT_WIDTH-1:0];
        sh_big = {1'b0, sh} >= (ialu_pkg::SHAMT_WIDTH+1)'(W);
        na     = i_req.op_signed & a[W-1];
        nb     = i_req.op_signed & b[W-1];
        n_entry         = '0;
        n_entry.valid   = i_req.valid;
        n_entry.mode    = i_req.mode;
        n_entry.err     = ((i_req.mode == ialu_pkg::MODE_DIV) ||
                           (i_req.mode == ialu_pkg::MODE_REM)) && (b == '0);
        n_entry.neg_res = (i_req.mode == ialu_pkg::MODE_DIV) ? (na ^ nb) : na;
        n_entry.dq      = na ? (W)'(-a) : a;
        n_entry.dvs     = nb ? (W)'(-b) : b;
        n_entry.ma      = a;
        n_entry.mb      = b;
        case (i_req.mode)
            ialu_pkg::MODE_ADD: n_entry.simple = a + b;
            ialu_pkg::MODE_SUB: n_entry.simple = a - b;
            ialu_pkg::MODE_AND: n_entry.simple = a & b;
            ialu_pkg::MODE_OR:  n_entry.simple = a | b;
            ialu_pkg::MODE_XOR: n_entry.simple = a ^ b;
            ialu_pkg::MODE_SHL: n_entry.simple = sh_big ? '0 : (a << sh);
            ialu_pkg::MODE_SHR: begin
                if (sh_big) begin
                    n_entry.simple = {W{na}};
                end else begin
                    n_entry.simple = na ? ~((~a) >> sh) : (a >> sh);
                end
            end
            default:            n_entry.simple = '0;
        endcase
    end

    // entry register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (en) begin
            r_entry <= n_entry;
        end
    end

    assign row[0] = r_entry;

    // row of step cells
    for (genvar i = 0; i < W; i++) begin : g_cell
        ialu_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_item (row[i]),
            .o_item (row[i+1])
        );
    end

    // result select and sign fix
    always_comb begin
        case (row[W].mode)
            ialu_pkg::MODE_MUL: n_res = row[W].acc;
            ialu_pkg::MODE_DIV: n_res = row[W].neg_res ? (W)'(-row[W].dq) : row[W].dq;
            ialu_pkg::MODE_REM: n_res = row[W].neg_res ? (W)'(-row[W].rem) : row[W].rem;
            default:            n_res = row[W].simple;
        endcase
        if (row[W].err) begin
            n_res = '0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= row[W].valid;
            r_out_res   <= n_res;
            r_out_err   <= row[W].err;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = (ialu_pkg::FIELD_WIDTH)'(r_out_res);
    assign o_rsp.divide_error = r_out_err;

    // an error response carries a zero result
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.divide_error |-> o_rsp.result_value == '0)
        else $error("divide error with nonzero result");

    // last cell feeds the result register when the row moves
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> r_out_valid == $past(row[W].valid))
        else $error("result valid lost at row end");

    // a held response freezes the row end
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(row[W].valid) && $stable(r_out_res))
        else $error("row moved during stall");
endmodule

// ===== tb/sv/tb_integer_alu_64bit.sv =====
// testbench of the 64-bit integer alu: random and directed requests checked against a predictor
module tb_integer_alu_64bit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = ialu_pkg::DATA_WIDTH + 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_REQUESTS = 1500;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [ialu_pkg::MODE_WIDTH-1:0]  mode;
        logic                             op_signed;
        logic [ialu_pkg::FIELD_WIDTH-1:0] operand_a;
        logic [ialu_pkg::FIELD_WIDTH-1:0] operand_b;
    } t_alu_req;

    typedef struct packed {
        logic [ialu_pkg::FIELD_WIDTH-1:0] result_value;
        logic                             divide_error;
    } t_alu_rsp;

    logic i_clk;
    logic i_rst_n;

    ialu_req_if req_ch ();
    ialu_rsp_if rsp_ch ();

    integer_alu_64bit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    t_alu_req pending_reqs[$];
    t_alu_rsp expected_rsps[$];
    int mismatch_count;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int stall_phase;
    int stall_period;
    logic req_fire_q;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // two's complement magnitude of a width-limited value
    function automatic logic [ialu_pkg::DATA_WIDTH-1:0] magnitude(
        input logic [ialu_pkg::DATA_WIDTH-1:0] v);
        return v[ialu_pkg::DATA_WIDTH-1] ? -v : v;
    endfunction

    // expected alu result for one request
    function automatic t_alu_rsp alu_predict(input t_alu_req r);
        t_alu_rsp o;
        logic [ialu_pkg::DATA_WIDTH-1:0] a, b, ma, mb, q;
        logic [ialu_pkg::SHAMT_WIDTH-1:0] sh;
        logic a_neg, b_neg;
        a  = r.operand_a[ialu_pkg::DATA_WIDTH-1:0];
        b  = r.operand_b[ialu_pkg::DATA_WIDTH-1:0];
        sh = r.operand_b[ialu_pkg::SHAMT_WIDTH-1:0];
        o  = '0;
        a_neg = r.op_signed && a[ialu_pkg::DATA_WIDTH-1];
        b_neg = r.op_signed && b[ialu_pkg::DATA_WIDTH-1];
        ma = a_neg ? magnitude(a) : a;
        mb = b_neg ? magnitude(b) : b;
        case (r.mode)
            ialu_pkg::MODE_ADD: o.result_value = a + b;
            ialu_pkg::MODE_SUB: o.result_value = a - b;
            ialu_pkg::MODE_MUL: o.result_value = a * b;
            ialu_pkg::MODE_DIV, ialu_pkg::MODE_REM: begin
                if (b == '0) begin
                    o.divide_error = 1'b1;
                end else if (r.mode == ialu_pkg::MODE_DIV) begin
                    q = ma / mb;
                    if (a_neg != b_neg) q = -q;
                    o.result_value = q;
                end else begin
                    q = ma % mb;
                    if (a_neg) q = -q;
                    o.result_value = q;
                end
            end
            ialu_pkg::MODE_AND: o.result_value = a & b;
            ialu_pkg::MODE_OR:  o.result_value = a | b;
            ialu_pkg::MODE_XOR: o.result_value = a ^ b;
            ialu_pkg::MODE_SHL: o.result_value = (sh >= ialu_pkg::DATA_WIDTH) ? '0 : a << sh;
            ialu_pkg::MODE_SHR: begin
                if (sh >= ialu_pkg::DATA_WIDTH)
                    o.result_value = {ialu_pkg::DATA_WIDTH{a_neg}};
                else if (a_neg)
                    o.result_value = ~((~a) >> sh);
                else
                    o.result_value = a >> sh;
            end
            default: o.result_value = '0;
        endcase
        return o;
    endfunction

    // random 64-bit value biased toward edge patterns
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            4: return 64'($urandom_range(0, 20));
            5: return -64'($urandom_range(1, 20));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_req(input logic [ialu_pkg::MODE_WIDTH-1:0] mode, input logic sgn,
                             input logic [63:0] a, input logic [63:0] b);
        t_alu_req r;
        r.mode = mode;
        r.op_signed = sgn;
        r.operand_a = a;
        r.operand_b = b;
        pending_reqs = {pending_reqs, r};
    endtask

    // stimulus and end of run
    initial begin
        t_alu_req r;
        logic [63:0] b;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: every operation, extremes, zero divisor, overflow division, shifts
        for (int m = 0; m < 10; m++)
            queue_req(ialu_pkg::MODE_WIDTH'(m), m[0], 64'hFFFF_FFFF_FFFF_FFFF,
                      64'h8000_0000_0000_0001);
        queue_req(ialu_pkg::MODE_DIV, 1'b1, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(ialu_pkg::MODE_REM, 1'b1, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(ialu_pkg::MODE_DIV, 1'b0, 64'd123, 64'd0);
        queue_req(ialu_pkg::MODE_REM, 1'b1, 64'd123, 64'd0);
        queue_req(ialu_pkg::MODE_DIV, 1'b1, -64'd7, 64'd2);
        queue_req(ialu_pkg::MODE_REM, 1'b1, -64'd7, 64'd2);
        queue_req(ialu_pkg::MODE_REM, 1'b1, 64'd7, -64'd2);
        queue_req(ialu_pkg::MODE_SHL, 1'b0, 64'h1, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(ialu_pkg::MODE_SHR, 1'b1, 64'h8000_0000_0000_0000, 64'd63);
        queue_req(ialu_pkg::MODE_SHR, 1'b0, 64'h8000_0000_0000_0000, 64'd63);
        queue_req(ialu_pkg::MODE_SHR, 1'b1, 64'h4000_0000_0000_0000, 64'h40);
        queue_req(4'd10, 1'b1, 64'd5, 64'd5);
        queue_req(4'd15, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(ialu_pkg::MODE_ADD, 1'b0, 64'd0, 64'd0);

        // random part, mostly legal modes
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            r.mode = ($urandom_range(0, 19) == 0)
                   ? ialu_pkg::MODE_WIDTH'($urandom_range(10, 15))
                   : ialu_pkg::MODE_WIDTH'($urandom_range(0, 9));
            r.op_signed = 1'($urandom_range(0, 1));
            b = pick_operand();
            if ((r.mode == ialu_pkg::MODE_SHL || r.mode == ialu_pkg::MODE_SHR) &&
                $urandom_range(0, 1))
                b = {32'($urandom), 26'($urandom), 6'($urandom_range(0, 63))};
            queue_req(r.mode, r.op_signed, pick_operand(), b);
        end

        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_ch.valid)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_rsps.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // request handshake seen at the last rising edge
    always @(posedge i_clk) begin
        req_fire_q <= i_rst_n && req_ch.valid && req_ch.ready;
    end

    // request driver: bursts with random gaps, changes on the falling edge
    always @(negedge i_clk) begin : p_drive
        t_alu_req d;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.mode <= '0;
            req_ch.op_signed <= 1'b0;
            req_ch.operand_a <= '0;
            req_ch.operand_b <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!req_ch.valid || req_fire_q) begin
            if (gap_left > 0 || pending_reqs.size() == 0) begin
                req_ch.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end else begin
                d = pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.mode <= d.mode;
                req_ch.op_signed <= d.op_signed;
                req_ch.operand_a <= d.operand_a;
                req_ch.operand_b <= d.operand_b;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // response sink stall pattern: ready is dropped at the start of every period of random length
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_phase <= 0;
            stall_period <= 5;
        end else begin
            rsp_ch.ready <= (stall_phase >= 2);
            if (stall_phase >= stall_period - 1) begin
                stall_phase <= 0;
                stall_period <= $urandom_range(3, 11);
            end else begin
                stall_phase <= stall_phase + 1;
            end
        end
    end

    // monitor: predict on request, compare on response, watchdog on idle cycles
    always @(posedge i_clk) begin : p_monitor
        t_alu_req rq;
        t_alu_rsp act;
        t_alu_rsp exp_rsp;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                rq.mode = req_ch.mode;
                rq.op_signed = req_ch.op_signed;
                rq.operand_a = req_ch.operand_a;
                rq.operand_b = req_ch.operand_b;
                expected_rsps = {expected_rsps, alu_predict(rq)};
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                act.result_value = rsp_ch.result_value;
                act.divide_error = rsp_ch.divide_error;
                if (expected_rsps.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected response: result %h error %b",
                                 act.result_value, act.divide_error);
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (act !== exp_rsp) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("mismatch: expected %h/%b actual %h/%b",
                                     exp_rsp.result_value, exp_rsp.divide_error,
                                     act.result_value, act.divide_error);
                    end
                end
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        mismatch_count = 0;
        idle_cycles = 0;
        req_fire_q = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = '0;
        req_ch.op_signed = 1'b0;
        req_ch.operand_a = '0;
        req_ch.operand_b = '0;
        rsp_ch.ready = 1'b0;
    end
endmodule

// ===== sim.f =====
hdl/ialu_pkg.sv
hdl/ialu_req_if.sv
hdl/ialu_rsp_if.sv
hdl/ialu_cell.sv
hdl/integer_alu_64bit.sv
tb/sv/tb_integer_alu_64bit.sv
